>>> rtl/gamp_pkg.sv
// Package: shared types and constants for the global alignment block.
package gamp_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int SYM_W       = 8;
    localparam int PEN_W       = 14;
    localparam int CFG_W       = 8;
    localparam int Q_DEPTH     = 4;

    localparam logic [SYM_W-1:0] GAP_SYM = 8'd95;
    localparam logic [PEN_W-1:0] PEN_MAX = 14'h3FFF;

    localparam logic SEL_X = 1'b0;
    localparam logic SEL_Y = 1'b1;

    localparam logic [0:0] REG_MISMATCH = 1'b0;
    localparam logic [0:0] REG_GAP      = 1'b1;

    typedef struct packed {
        logic             sel;
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_ROW, S_FRD, S_FWR, S_TOT, S_TOTC,
        S_TBSEL, S_TBCUR, S_TBD, S_TBU, S_TBL, S_TBW,
        S_PXR, S_PXW, S_PYR, S_PYW, S_ERD, S_ELD, S_EWT
    } t_state;

endpackage

>>> rtl/gamp_ram.sv
// Generic simple dual-port RAM with registered read.
module gamp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/gamp_front.sv
// Front end: accepts input words and queues them for the back end.
module gamp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  gamp_pkg::t_item      i_item,
    output logic                 o_avail,
    output gamp_pkg::t_item      o_item,
    input  logic                 i_pop
);
    import gamp_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_item           r_q [Q_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != (PW+1)'(Q_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

>>> rtl/gamp_back.sv
// Back end: sequence stores, matrix fill, traceback and column output.
module gamp_back #(
    parameter int MAX_LEN = gamp_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  gamp_pkg::t_item               i_item,
    output logic                          o_pop,
    input  logic [gamp_pkg::CFG_W-1:0]    i_mismatch,
    input  logic [gamp_pkg::CFG_W-1:0]    i_gap,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gamp_pkg::SYM_W-1:0]    o_x,
    output logic [gamp_pkg::SYM_W-1:0]    o_y,
    output logic [gamp_pkg::PEN_W-1:0]    o_total,
    output logic                          o_last
);
    import gamp_pkg::*;

    localparam int DIM = MAX_LEN + 1;
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int SA  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SD  = (MAX_LEN > 1) ? MAX_LEN : 2;
    localparam int MD  = DIM * DIM;
    localparam int MA  = $clog2(MD);
    localparam int BD  = 2 * MAX_LEN;
    localparam int BA  = $clog2(BD);
    localparam int CNW = $clog2(BD + 1);
    localparam int CW  = $clog2(2 * MAX_LEN * 255 + 256) + 1;

    t_state r_st, n_st;

    logic [LW-1:0]  r_lx, n_lx, r_ly, n_ly, r_i, n_i, r_j, n_j;
    logic           r_xc, n_xc;
    logic [CW-1:0]  r_diag, n_diag, r_left, n_left, r_up, n_up, r_cur, n_cur;
    logic [CW-1:0]  r_bord, n_bord;
    logic [SYM_W-1:0] r_xs, n_xs, r_ys, n_ys;
    logic [CNW-1:0] r_cnt, n_cnt, r_k, n_k;
    logic [PEN_W-1:0] r_tot, n_tot;
    logic           r_ov, n_ov;
    logic [SYM_W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic           r_ol, n_ol;

    // memory ports
    logic             x_we, y_we, m_we, b_we;
    logic [SA-1:0]    x_wa, x_ra, y_wa, y_ra;
    logic [SYM_W-1:0] x_rd, y_rd;
    logic [MA-1:0]    m_wa, m_ra;
    logic [CW-1:0]    m_wd, m_rd;
    logic [BA-1:0]    b_wa, b_ra;
    logic [2*SYM_W-1:0] b_wd, b_rd;

    logic [LW-1:0]  lx_eff;
    logic [CW-1:0]  gap_w, mm_w, c_v, c_up, c_left, c_diag;
    logic           sym_eq;

    function automatic logic [MA-1:0] addr(input logic [LW-1:0] i, input logic [LW-1:0] j);
        logic [MA+LW-1:0] a;
        a = (MA+LW)'(i) * (MA+LW)'(DIM) + (MA+LW)'(j);
        return a[MA-1:0];
    endfunction

    gamp_ram #(.WIDTH(SYM_W), .DEPTH(SD)) u_xram (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_wa), .i_wdata(i_item.sym),
        .i_raddr(x_ra), .o_rdata(x_rd));
    gamp_ram #(.WIDTH(SYM_W), .DEPTH(SD)) u_yram (
        .i_clk(i_clk), .i_we(y_we), .i_waddr(y_wa), .i_wdata(i_item.sym),
        .i_raddr(y_ra), .o_rdata(y_rd));
    gamp_ram #(.WIDTH(CW), .DEPTH(MD)) u_mram (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));
    gamp_ram #(.WIDTH(2*SYM_W), .DEPTH(BD)) u_bram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(b_ra), .o_rdata(b_rd));

    assign gap_w  = CW'(i_gap);
    assign mm_w   = CW'(i_mismatch);
    assign lx_eff = r_xc ? '0 : r_lx;

    // cell value for the fill step
    assign c_up   = m_rd + gap_w;
    assign c_left = r_left + gap_w;
    assign c_diag = r_diag + mm_w;
    assign sym_eq = (x_rd == y_rd);
    always_comb begin
        c_v = c_diag;
        if (c_up < c_v)   c_v = c_up;
        if (c_left < c_v) c_v = c_left;
        if (sym_eq)       c_v = r_diag;
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_avail && i_item.sel == SEL_Y && i_item.last) n_st = S_INIT;
            S_INIT:  if (r_j == r_ly) n_st = (r_lx != '0) ? S_ROW : S_TOT;
            S_ROW:   n_st = S_FRD;
            S_FRD:   n_st = S_FWR;
            S_FWR:   if (r_j == r_ly) n_st = (r_i == r_lx) ? S_TOT : S_ROW;
                     else n_st = S_FRD;
            S_TOT:   n_st = S_TOTC;
            S_TOTC:  n_st = S_TBSEL;
            S_TBSEL: begin
                if (r_i != '0 && r_j != '0) n_st = S_TBCUR;
                else if (r_i != '0)         n_st = S_PXR;
                else if (r_j != '0)         n_st = S_PYR;
                else                        n_st = S_ERD;
            end
            S_TBCUR: n_st = S_TBD;
            S_TBD:   n_st = S_TBU;
            S_TBU:   n_st = S_TBL;
            S_TBL:   n_st = S_TBW;
            S_TBW:   n_st = S_TBSEL;
            S_PXR:   n_st = S_PXW;
            S_PXW:   n_st = S_TBSEL;
            S_PYR:   n_st = S_PYW;
            S_PYW:   n_st = S_TBSEL;
            S_ERD:   n_st = S_ELD;
            S_ELD:   n_st = S_EWT;
            S_EWT:   if (i_ready) n_st = (r_k == '0) ? S_IDLE : S_ERD;
            default: n_st = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_lx = r_lx; n_ly = r_ly; n_xc = r_xc; n_i = r_i; n_j = r_j;
        n_diag = r_diag; n_left = r_left; n_up = r_up; n_cur = r_cur;
        n_bord = r_bord; n_xs = r_xs; n_ys = r_ys; n_cnt = r_cnt; n_k = r_k;
        n_tot = r_tot; n_ov = r_ov; n_ox = r_ox; n_oy = r_oy; n_ol = r_ol;
        o_pop = 1'b0;
        x_we = 1'b0; y_we = 1'b0; m_we = 1'b0; b_we = 1'b0;
        x_wa = lx_eff[SA-1:0]; y_wa = r_ly[SA-1:0];
        x_ra = SA'(r_i - 1'b1); y_ra = SA'(r_j - 1'b1);
        m_wa = addr(r_i, r_j); m_wd = r_bord; m_ra = addr(r_i, r_j);
        b_wa = r_cnt[BA-1:0]; b_wd = {r_xs, r_ys};
        b_ra = BA'(r_k);
        case (r_st)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (i_item.sel == SEL_X) begin
                        n_lx = lx_eff;
                        if (lx_eff != LW'(MAX_LEN)) begin
                            x_we = 1'b1;
                            n_lx = lx_eff + 1'b1;
                        end
                        n_xc = i_item.last;
                    end else begin
                        if (r_ly != LW'(MAX_LEN)) begin
                            y_we = 1'b1;
                            n_ly = r_ly + 1'b1;
                        end
                        if (i_item.last) begin
                            n_i    = '0;
                            n_j    = '0;
                            n_bord = '0;
                        end
                    end
                end
            end
            S_INIT: begin
                // top border row
                m_we   = 1'b1;
                m_wa   = addr('0, r_j);
                n_j    = r_j + 1'b1;
                n_bord = r_bord + gap_w;
                if (r_j == r_ly) begin
                    n_i    = LW'(1);
                    n_bord = '0;
                end
            end
            S_ROW: begin
                // left border cell, r_bord holds (i-1)*gap
                m_we   = 1'b1;
                m_wa   = addr(r_i, '0);
                m_wd   = r_bord + gap_w;
                n_diag = r_bord;
                n_left = r_bord + gap_w;
                n_bord = r_bord + gap_w;
                n_j    = LW'(1);
            end
            S_FRD: begin
                m_ra = addr(r_i - 1'b1, r_j);
            end
            S_FWR: begin
                m_we   = 1'b1;
                m_wd   = c_v;
                n_diag = m_rd;
                n_left = c_v;
                n_j    = r_j + 1'b1;
                if (r_j == r_ly) n_i = r_i + 1'b1;
            end
            S_TOT: begin
                m_ra = addr(r_lx, r_ly);
            end
            S_TOTC: begin
                n_tot = (m_rd > CW'(PEN_MAX)) ? PEN_MAX : m_rd[PEN_W-1:0];
                n_i   = r_lx;
                n_j   = r_ly;
                n_cnt = '0;
            end
            S_TBSEL: begin
                n_k = r_cnt - 1'b1;
            end
            S_TBCUR: begin
                m_ra = addr(r_i, r_j);
            end
            S_TBD: begin
                n_cur = m_rd;
                n_xs  = x_rd;
                n_ys  = y_rd;
                m_ra  = addr(r_i - 1'b1, r_j - 1'b1);
            end
            S_TBU: begin
                n_diag = m_rd;
                m_ra   = addr(r_i - 1'b1, r_j);
            end
            S_TBL: begin
                n_up = m_rd;
                m_ra = addr(r_i, r_j - 1'b1);
            end
            S_TBW: begin
                b_we  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_xs == r_ys || r_diag + mm_w == r_cur) begin
                    n_i = r_i - 1'b1;
                    n_j = r_j - 1'b1;
                end else if (r_up + gap_w == r_cur) begin
                    b_wd = {r_xs, GAP_SYM};
                    n_i  = r_i - 1'b1;
                end else if (m_rd + gap_w == r_cur) begin
                    b_wd = {GAP_SYM, r_ys};
                    n_j  = r_j - 1'b1;
                end else begin
                    n_i = r_i - 1'b1;
                    n_j = r_j - 1'b1;
                end
            end
            S_PXR: ;
            S_PXW: begin
                b_we  = 1'b1;
                b_wd  = {x_rd, GAP_SYM};
                n_cnt = r_cnt + 1'b1;
                n_i   = r_i - 1'b1;
            end
            S_PYR: ;
            S_PYW: begin
                b_we  = 1'b1;
                b_wd  = {GAP_SYM, y_rd};
                n_cnt = r_cnt + 1'b1;
                n_j   = r_j - 1'b1;
            end
            S_ERD: ;
            S_ELD: begin
                n_ov = 1'b1;
                n_ox = b_rd[2*SYM_W-1:SYM_W];
                n_oy = b_rd[SYM_W-1:0];
                n_ol = (r_k == '0);
            end
            S_EWT: begin
                if (i_ready) begin
                    n_ov = 1'b0;
                    n_k  = r_k - 1'b1;
                    if (r_k == '0) begin
                        n_lx = '0;
                        n_ly = '0;
                        n_xc = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_diag <= n_diag; r_left <= n_left; r_up <= n_up;
        r_cur <= n_cur; r_bord <= n_bord; r_xs <= n_xs; r_ys <= n_ys;
        r_cnt <= n_cnt; r_k <= n_k; r_tot <= n_tot;
        r_ox <= n_ox; r_oy <= n_oy; r_ol <= n_ol;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_lx <= '0;
            r_ly <= '0;
            r_xc <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_lx <= n_lx;
            r_ly <= n_ly;
            r_xc <= n_xc;
            r_ov <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_total = r_tot;
    assign o_last  = r_ol;
endmodule

>>> rtl/global_alignment_min_penalty.sv
// Top level: global sequence alignment at minimum penalty.
//
//  channel   | dir | payload
//  s_axis    | in  | tdata[7:0] symbol, tuser seq_select, tlast last_symbol
//  m_axis    | out | tdata x_column, y_column, total_penalty; tlast last_column
//  apb       | in  | 0x0 mismatch_penalty, 0x4 gap_penalty
//
// Loading words are queued (4 deep) and stored one per cycle while the back end is idle.
// Last Y word: top border row, a left border cell per row, then per matrix
// cell a read of the cell above, then compute and write; each traceback step
// reads four cells, padding columns follow, and output columns wait for m_axis_tready.
// The single-port-read matrix RAM sets the fill rate.
// Reset (synchronous, active low) clears lengths, state and valids.
// The queue keeps taking words while an alignment runs or output stalls, until it is full.
module global_alignment_min_penalty #(
    parameter int MAX_LEN = gamp_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tuser,   // [0] seq_select
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] x_column, [15:8] y_column, [29:16] total
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gamp_pkg::*;

    logic [CFG_W-1:0] r_mismatch, r_gap;
    t_item            in_item, q_item;
    logic             q_avail, q_pop;
    logic [SYM_W-1:0] ox, oy;
    logic [PEN_W-1:0] otot;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch <= 8'd3;
            r_gap      <= 8'd2;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MISMATCH: r_mismatch <= pwdata[CFG_W-1:0];
                REG_GAP:      r_gap      <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MISMATCH: prdata = {24'd0, r_mismatch};
            REG_GAP:      prdata = {24'd0, r_gap};
            default:      prdata = '0;
        endcase
    end

    assign in_item = '{sel: s_axis_tuser, sym: s_axis_tdata, last: s_axis_tlast};

    gamp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_avail(q_avail), .o_item(q_item), .i_pop(q_pop));

    gamp_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_avail(q_avail), .i_item(q_item), .o_pop(q_pop),
        .i_mismatch(r_mismatch), .i_gap(r_gap),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(ox), .o_y(oy), .o_total(otot), .o_last(m_axis_tlast));

    assign m_axis_tdata = {2'b00, otot, oy, ox};
endmodule

>>> rtl/gamp_checker.sv
// Port-level checks for the alignment block, bound to the top level.
module gamp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
        else $error("padding bits set");
    a_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tdata[29:16] == $past(m_axis_tdata[29:16]))
        else $error("total changed within one alignment");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind global_alignment_min_penalty gamp_checker u_gamp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast), .pready(pready));
